// ===== hw/rtl/ihl_pkg.sv =====
// ---------------------------------------------------------------------------
// ihl_pkg
// Shared types and codes for the indexed handle list.
// ---------------------------------------------------------------------------
package ihl_pkg;

    localparam int CAPACITY_DEF     = 16;
    localparam int HANDLE_WIDTH_DEF = 32;

    // port widths of the request and result beats
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 5;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // code 7 has no meaning and falls to the default arm
    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND = 3'd0,
        FN_INSERT = 3'd1,
        FN_GET    = 3'd2,
        FN_POP    = 3'd3,
        FN_PEEK   = 3'd4,
        FN_DELETE = 3'd5,
        FN_CLEAR  = 3'd6
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

    // shift command broadcast to every cell
    typedef struct packed {
        logic ins;   // cell at slot loads handle, cells above take left neighbor
        logic del;   // cells at slot and above take right neighbor
    } t_cell_cmd;

endpackage

// ===== hw/rtl/indexed_handle_list_top.sv =====
// ---------------------------------------------------------------------------
// indexed_handle_list_top
// Ordered list of nonzero handles with array-list and stack operations.
// ---------------------------------------------------------------------------
// each request is taken when start is high and busy is low; busy stays low,
// so a new request can be issued on every clock. the result beat appears on
// the o_ result ports one cycle after the request is taken and is marked by
// o_done for exactly that one cycle: the receiver cannot stall and must take
// it then. every operation, including insert and delete in the middle of the
// list, takes one clock, because the entries sit in a row of cells that all
// shift toward or away from the target slot in the same clock edge. a read
// (get, pop, peek) selects one cell by its index and the result register
// captures it. handles are kept in their low HANDLE_WIDTH bits (at most 32);
// o_count is the entry count after the request, in its low five bits.
module indexed_handle_list_top #(
    parameter int CAPACITY     = ihl_pkg::CAPACITY_DEF,
    parameter int HANDLE_WIDTH = ihl_pkg::HANDLE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ihl_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [ihl_pkg::POS_W-1:0]    i_position,
    input  logic [ihl_pkg::HANDLE_W-1:0]        i_handle,
    output logic                                o_done,
    output logic [ihl_pkg::HANDLE_W-1:0]        o_value,
    output logic                                o_found,
    output logic [ihl_pkg::STATUS_W-1:0]        o_status,
    output logic [ihl_pkg::COUNT_W-1:0]         o_count
);
    import ihl_pkg::*;

    // stored handle width, limited by the 32-bit handle port
    localparam int HW = (HANDLE_WIDTH < HANDLE_W) ? HANDLE_WIDTH : HANDLE_W;
    localparam int SW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    logic          w_accept;
    logic [HW-1:0] w_handle;
    t_cell_cmd     w_cmd;
    logic [SW-1:0] w_wr_slot;
    logic [SW-1:0] w_rd_slot;
    logic          w_found;
    t_status       w_status;
    logic [LW-1:0] w_len_next;
    logic [HW-1:0] w_data [CAPACITY];
    logic [HW-1:0] w_tap  [CAPACITY];
    logic [HW-1:0] w_rd;

    // result beat registers
    logic                r_done;
    logic [HANDLE_W-1:0] r_value;
    logic                r_found;
    t_status             r_status;
    logic [COUNT_W-1:0]  r_count;
    logic [HANDLE_W-1:0] n_value;
    logic [COUNT_W-1:0]  n_count;

    // busy is tied low, so there is never back-pressure
    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_handle = i_handle[HW-1:0];

    ihl_ctrl #(
        .CAPACITY (CAPACITY),
        .SW       (SW),
        .LW       (LW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_func        (t_func'(i_func)),
        .i_position    (i_position),
        .i_handle_zero (w_handle == '0),
        .o_cmd         (w_cmd),
        .o_wr_slot     (w_wr_slot),
        .o_rd_slot     (w_rd_slot),
        .o_found       (w_found),
        .o_status      (w_status),
        .o_len_next    (w_len_next)
    );

    // row of entry cells; the two end cells see zero past the edge of the row
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [HW-1:0] w_left;
        logic [HW-1:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[k+1];
        end

        ihl_cell #(
            .HW  (HW),
            .SW  (SW),
            .IDX (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (w_cmd),
            .i_wr_slot (w_wr_slot),
            .i_rd_slot (w_rd_slot),
            .i_handle  (w_handle),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_data    (w_data[k]),
            .o_tap     (w_tap[k])
        );
    end

    // only the addressed cell drives its tap, so the read is an or of all taps
    always_comb begin
        w_rd = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd = w_rd | w_tap[k];
        end
    end

    // widen read data and narrow length to the fixed port widths
    always_comb begin
        logic [HW+HANDLE_W-1:0] v_val_ext;
        logic [LW+COUNT_W-1:0]  v_cnt_ext;
        v_val_ext = {{HANDLE_W{1'b0}}, (w_found ? w_rd : {HW{1'b0}})};
        v_cnt_ext = {{COUNT_W{1'b0}}, w_len_next};
        n_value   = v_val_ext[HANDLE_W-1:0];
        n_count   = v_cnt_ext[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_accept;
        end
    end

    // payload is only meaningful while r_done is high
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value  <= n_value;
            r_found  <= w_found;
            r_status <= w_status;
            r_count  <= n_count;
        end
    end

    assign o_done   = r_done;
    assign o_value  = r_value;
    assign o_found  = r_found;
    assign o_status = r_status;
    assign o_count  = r_count;

    // a taken request yields a result beat on the next clock
    property p_beat_follows;
        @(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done;
    endproperty
    a_beat_follows: assert property (p_beat_follows) else $error("result beat missing");

    // no result beat without a request the clock before
    property p_no_spurious;
        @(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_done;
    endproperty
    a_no_spurious: assert property (p_no_spurious) else $error("unrequested result beat");

    // a real read reports ok status; a beat that found no entry returns zero
    property p_found_ok;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> (o_status == ST_OK);
    endproperty
    a_found_ok: assert property (p_found_ok) else $error("found with error status");

    property p_not_found_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (o_value == '0);
    endproperty
    a_not_found_zero: assert property (p_not_found_zero) else $error("value without entry");

    // clear always empties the list
    property p_clear_empties;
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == FN_CLEAR) |=> (o_count == '0);
    endproperty
    a_clear_empties: assert property (p_clear_empties) else $error("clear left entries");

endmodule

// ===== hw/rtl/ihl_cell.sv =====
// ---------------------------------------------------------------------------
// ihl_cell
// One list entry: shifts up on insert, down on delete, taps out on read.
// ---------------------------------------------------------------------------
module ihl_cell #(
    parameter int HW  = 32,
    parameter int SW  = 4,
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  ihl_pkg::t_cell_cmd i_cmd,
    input  logic [SW-1:0]     i_wr_slot,
    input  logic [SW-1:0]     i_rd_slot,
    input  logic [HW-1:0]     i_handle,
    input  logic [HW-1:0]     i_left,
    input  logic [HW-1:0]     i_right,
    output logic [HW-1:0]     o_data,
    output logic [HW-1:0]     o_tap
);
    import ihl_pkg::*;

    localparam logic [SW-1:0] MY_IDX = SW'(IDX);

    logic [HW-1:0] r_data;
    logic [HW-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (i_wr_slot == MY_IDX) begin
                n_data = i_handle;
            end else if (i_wr_slot < MY_IDX) begin
                n_data = i_left;
            end
        end else if (i_cmd.del) begin
            if (i_wr_slot <= MY_IDX) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = (i_rd_slot == MY_IDX) ? r_data : '0;

endmodule

// ===== hw/rtl/ihl_ctrl.sv =====
// ---------------------------------------------------------------------------
// ihl_ctrl
// Length register, index resolution and per-request decode.
// ---------------------------------------------------------------------------
module ihl_ctrl #(
    parameter int CAPACITY = 16,
    parameter int SW       = 4,
    parameter int LW       = 5
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  ihl_pkg::t_func                   i_func,
    input  logic signed [ihl_pkg::POS_W-1:0] i_position,
    input  logic                             i_handle_zero,
    output ihl_pkg::t_cell_cmd               o_cmd,
    output logic [SW-1:0]                    o_wr_slot,
    output logic [SW-1:0]                    o_rd_slot,
    output logic                             o_found,
    output ihl_pkg::t_status                 o_status,
    output logic [LW-1:0]                    o_len_next
);
    import ihl_pkg::*;

    localparam int RW = ((LW > POS_W) ? LW : POS_W) + 1;
    localparam logic [LW-1:0] CAP_LEN = LW'(CAPACITY);

    logic [LW-1:0]        r_len;
    logic [LW-1:0]        n_len;
    logic signed [RW-1:0] w_pos_ext;
    logic signed [RW-1:0] w_len_ext;
    logic signed [RW-1:0] w_idx;
    logic                 w_in_range;
    logic [SW-1:0]        w_slot;
    logic [SW-1:0]        w_last;
    t_cell_cmd            w_cmd;

    // negative index counts back from the end
    always_comb begin
        w_pos_ext  = RW'(i_position);
        w_len_ext  = $signed(RW'(r_len));
        w_idx      = i_position[POS_W-1] ? (w_len_ext + w_pos_ext) : w_pos_ext;
        w_in_range = !w_idx[RW-1] && (w_idx < w_len_ext);
        w_slot     = w_idx[SW-1:0];
        w_last     = SW'(r_len - LW'(1));
    end

    always_comb begin
        w_cmd     = '0;
        o_wr_slot = '0;
        o_rd_slot = '0;
        o_found   = 1'b0;
        o_status  = ST_OK;
        n_len     = r_len;
        case (i_func)
            FN_APPEND, FN_INSERT: begin
                if (i_handle_zero) begin
                    o_status = ST_ZERO;
                end else if (r_len == CAP_LEN) begin
                    o_status = ST_FULL;
                end else begin
                    w_cmd.ins = 1'b1;
                    o_wr_slot = (i_func == FN_INSERT && w_in_range) ? w_slot
                                                                    : SW'(r_len);
                    n_len     = r_len + LW'(1);
                end
            end
            FN_GET: begin
                if (w_in_range) begin
                    o_rd_slot = w_slot;
                    o_found   = 1'b1;
                end else begin
                    o_status = ST_RANGE;
                end
            end
            FN_POP, FN_PEEK: begin
                if (r_len == '0) begin
                    o_status = ST_RANGE;
                end else begin
                    o_rd_slot = w_last;
                    o_found   = 1'b1;
                    if (i_func == FN_POP) begin
                        n_len = r_len - LW'(1);
                    end
                end
            end
            FN_DELETE: begin
                if (w_in_range) begin
                    w_cmd.del = 1'b1;
                    o_wr_slot = w_slot;
                    n_len     = r_len - LW'(1);
                end else begin
                    o_status = ST_RANGE;
                end
            end
            FN_CLEAR: begin
                n_len = '0;
            end
            default: begin
            end
        endcase
    end

    assign o_cmd      = i_accept ? w_cmd : '0;
    assign o_len_next = n_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_accept) begin
            r_len <= n_len;
        end
    end

    property p_len_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CAP_LEN;
    endproperty
    a_len_bound: assert property (p_len_bound) else $error("length above capacity");

    property p_full_only_at_cap;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_status == ST_FULL) |-> (r_len == CAP_LEN);
    endproperty
    a_full_only_at_cap: assert property (p_full_only_at_cap)
        else $error("full reported below capacity");

    property p_shift_changes_len;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.ins || o_cmd.del) |=> (r_len != $past(r_len));
    endproperty
    a_shift_changes_len: assert property (p_shift_changes_len)
        else $error("shift without length change");

endmodule

// ===== test/tb_indexed_handle_list_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_indexed_handle_list_top
// Self-checking bench for the indexed handle list.
// ---------------------------------------------------------------------------
// requests go in through the start/busy command port
// a shadow copy of the list works out the result beat of each taken request
// a checker compares each o_done beat field by field with the oldest pending one
// directed requests cover the edges of the list first
// random traffic then runs in three phases with different sender gaps
// ---------------------------------------------------------------------------
module tb_indexed_handle_list_top;
    import ihl_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CAP         = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_TAIL  = 4;       // result register is one stage deep
    localparam int REPORT_MAX  = 10;
    // code 7 is outside t_func and must leave the list untouched
    localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

    typedef struct packed {
        logic [HANDLE_W-1:0] value;
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_list_result;

    // dut ports, all inputs known from time zero
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [FUNC_W-1:0]         i_func = '0;
    logic signed [POS_W-1:0]   i_position = '0;
    logic [HANDLE_W-1:0]       i_handle = '0;
    logic                      o_done;
    logic [HANDLE_W-1:0]       o_value;
    logic                      o_found;
    logic [STATUS_W-1:0]       o_status;
    logic [COUNT_W-1:0]        o_count;

    // shadow list, updated at the edge where a request beat is taken
    logic [HANDLE_W-1:0] shadow_entries [CAP];
    int                  shadow_len = 0;

    t_list_result pending_results [$];
    int           mismatch_count = 0;
    int           send_idle_pct = 0;
    int           cycle_count = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    indexed_handle_list_top #(
        .CAPACITY     (CAP),
        .HANDLE_WIDTH (HANDLE_WIDTH_DEF)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_func     (i_func),
        .i_position (i_position),
        .i_handle   (i_handle),
        .o_done     (o_done),
        .o_value    (o_value),
        .o_found    (o_found),
        .o_status   (o_status),
        .o_count    (o_count)
    );

    // apply one request to the shadow list and return the beat it should give
    function automatic t_list_result list_apply(input logic [FUNC_W-1:0] func,
                                                input logic signed [POS_W-1:0] pos,
                                                input logic [HANDLE_W-1:0] handle);
        t_list_result res;
        int           slot;
        int           k;
        bit           in_range;
        res = '0;
        res.status = ST_OK;
        // negative index counts back from the end, -1 is the last entry
        slot = (pos < 0) ? shadow_len + int'(pos) : int'(pos);
        in_range = (slot >= 0) && (slot < shadow_len);
        case (func)
            FN_APPEND, FN_INSERT: begin
                // zero handle wins over a full list
                if (handle == '0) begin
                    res.status = ST_ZERO;
                end else if (shadow_len >= CAP) begin
                    res.status = ST_FULL;
                end else if (func == FN_INSERT && in_range) begin
                    for (k = shadow_len; k > slot; k--)
                        shadow_entries[k] = shadow_entries[k-1];
                    shadow_entries[slot] = handle;
                    shadow_len++;
                end else begin
                    // append, or insert with an index out of range
                    shadow_entries[shadow_len] = handle;
                    shadow_len++;
                end
            end
            FN_GET: begin
                if (in_range) begin
                    res.value = shadow_entries[slot];
                    res.found = 1'b1;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            FN_POP, FN_PEEK: begin
                if (shadow_len == 0) begin
                    res.status = ST_RANGE;
                end else begin
                    res.value = shadow_entries[shadow_len-1];
                    res.found = 1'b1;
                    if (func == FN_POP)
                        shadow_len--;
                end
            end
            FN_DELETE: begin
                if (in_range) begin
                    for (k = slot; k + 1 < shadow_len; k++)
                        shadow_entries[k] = shadow_entries[k+1];
                    shadow_len--;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            FN_CLEAR: shadow_len = 0;
            default: ;
        endcase
        res.count = COUNT_W'(shadow_len);
        return res;
    endfunction

    // one request beat: optional sender gap, then hold start until taken
    task automatic send_request(input logic [FUNC_W-1:0] func,
                                input logic signed [POS_W-1:0] pos,
                                input logic [HANDLE_W-1:0] handle);
        if ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
            // junk on the fields while start is low must be ignored
            i_func = FUNC_W'($urandom);
            i_position = POS_W'($urandom);
            i_handle = $urandom;
            repeat ($urandom_range(2)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start = 1'b1;
        i_func = func;
        i_position = pos;
        i_handle = handle;
        // busy read here is its value before the edge
        do @(posedge i_clk); while (busy);
        pending_results.push_back(list_apply(func, pos, handle));
    endtask

    // sender pauses until every pending result beat has come back
    task automatic wait_for_results();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input t_list_result exp_r,
                                 input t_list_result act_r);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display({"%0t %s: exp value=%h found=%b status=%0d count=%0d, ",
                      "got value=%h found=%b status=%0d count=%0d"},
                     $realtime, what, exp_r.value, exp_r.found, exp_r.status,
                     exp_r.count, act_r.value, act_r.found, act_r.status,
                     act_r.count);
    endtask

    // result checker, every o_done beat is taken at the edge closing its cycle
    always @(posedge i_clk) begin : check_beat
        t_list_result exp_r;
        t_list_result act_r;
        act_r = '{value: o_value, found: o_found, status: o_status, count: o_count};
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result beat with nothing pending", '0, act_r);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_value !== exp_r.value || o_found !== exp_r.found ||
                    o_status !== exp_r.status || o_count !== exp_r.count)
                    note_mismatch("result mismatch", exp_r, act_r);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_indexed_handle_list_top: FAIL");
            $finish;
        end
    end

    // edges of an empty and a short list, every operation, unknown code
    task automatic test_directed();
        send_idle_pct = 0;
        send_request(FN_PEEK, 0, '0);                 // peek on empty list
        send_request(FN_POP, 0, '0);                  // pop on empty list
        send_request(FN_GET, 0, '0);                  // get on empty list
        send_request(FN_DELETE, -1, '0);              // delete on empty list
        send_request(FN_APPEND, 0, '0);               // zero handle rejected
        send_request(FN_INSERT, 3, '0);
        send_request(FN_APPEND, 15, 32'hFFFF_FFFF);
        send_request(FN_APPEND, -16, 32'h0000_0001);
        send_request(FN_INSERT, 0, 32'hA5A5_0001);    // insert at the front
        send_request(FN_INSERT, -1, 32'h5A5A_0002);   // insert before the last
        send_request(FN_INSERT, 15, 32'h8000_0000);   // past the end, appends
        send_request(FN_INSERT, -16, 32'h1234_5678);  // below minus length, appends
        send_request(FN_GET, -1, 32'hFFFF_FFFF);
        send_request(FN_GET, -6, '0);                 // minus length is entry zero
        send_request(FN_GET, -7, '0);                 // one further is out of range
        send_request(FN_GET, 6, '0);                  // index equal to length
        send_request(FN_PEEK, 0, '0);
        send_request(FN_DELETE, 2, '0);               // delete in the middle
        send_request(FN_DELETE, -1, '0);              // delete the last entry
        send_request(FN_DELETE, 0, '0);               // delete the first entry
        send_request(FN_DELETE, 15, '0);              // out of range
        send_request(FN_UNUSED, 1, 32'hDEAD_BEEF);    // unknown code ignored
        send_request(FN_POP, 0, '0);
        send_request(FN_CLEAR, 0, '0);
        send_request(FN_GET, 0, '0);
    endtask

    // fill to capacity, then full and zero-handle checks on a full list
    task automatic test_full_list();
        int n;
        send_idle_pct = 0;
        for (n = 0; n < CAP; n++)
            send_request(FN_APPEND, POS_W'($urandom), $urandom_range(32'hFFFF_FFFF, 1));
        send_request(FN_APPEND, 0, 32'h0000_0001);    // full
        send_request(FN_INSERT, 3, 32'h0000_0002);    // full
        send_request(FN_INSERT, 3, '0);               // zero check comes first
        send_request(FN_GET, -16, '0);                // entry zero on a full list
        send_request(FN_GET, 15, '0);
        send_request(FN_DELETE, -16, '0);
        send_request(FN_INSERT, -1, 32'hFFFF_FFFF);   // refill before the last
        send_request(FN_POP, 0, '0);
        send_request(FN_PEEK, 0, '0);
        send_request(FN_CLEAR, 0, '0);
    endtask

    // random traffic that keeps the length wandering over the whole range
    task automatic test_random(input int idle_pct, input int n_items);
        int                      done_items;
        int                      roll;
        int                      grow;
        logic [FUNC_W-1:0]       func;
        logic signed [POS_W-1:0] pos;
        logic [HANDLE_W-1:0]     handle;
        send_idle_pct = idle_pct;
        done_items = 0;
        while (done_items < n_items) begin
            grow = (shadow_len < CAP / 2) ? 50 : 35;
            roll = $urandom_range(99);
            if (roll < grow)
                func = $urandom_range(1) ? FN_INSERT : FN_APPEND;
            else if (roll < grow + 25)
                func = $urandom_range(1) ? FN_DELETE : FN_POP;
            else if (roll < grow + 40)
                func = FN_GET;
            else if (roll < grow + 45)
                func = FN_PEEK;
            else if (roll < grow + 47)
                func = FN_CLEAR;
            else if (roll < grow + 49)
                func = FN_UNUSED;
            else
                func = FN_GET;
            // on a nonempty list half of the indexes land inside it, the rest anywhere
            if (shadow_len > 0 && $urandom_range(1))
                pos = $urandom_range(1) ? POS_W'($urandom_range(shadow_len - 1))
                                        : POS_W'(-int'($urandom_range(shadow_len, 1)));
            else
                pos = POS_W'($urandom);
            case ($urandom_range(19))
                0:       handle = '0;
                1:       handle = '1;
                default: handle = $urandom;
            endcase
            send_request(func, pos, handle);
            if (func != FN_UNUSED)
                done_items++;
        end
    endtask

    initial begin
        // synchronous reset held low before the tests start
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        wait_for_results();
        test_full_list();
        wait_for_results();
        test_random(18, 340);
        wait_for_results();
        test_random(61, 330);
        wait_for_results();
        test_random(0, 330);
        wait_for_results();

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb_indexed_handle_list_top: PASS");
        end else begin
            $display("tb_indexed_handle_list_top: FAIL");
        end
        $finish;
    end

endmodule
